/* hw/rtl/apls_pkg.sv */
// ----------------------------------------------------------------------------
// apls_pkg: shared definitions for the proximal lasso solver.
// Widths, fixed-point constants, request codes, sequencer states and the
// request and response structures of the shared divider.
// ----------------------------------------------------------------------------
package apls_pkg;

	localparam int MAX_DIM   = 64;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int DIV_W     = 64;

	localparam logic [WORD_W-1:0] QONE       = 32'd1 << FRAC_BITS;
	localparam logic [63:0]       ONE2       = 64'd1 << (2 * FRAC_BITS);
	localparam logic [63:0]       TSQ_LIMIT  = (64'hFFFF_FFFF_FFFF_FFFF - ONE2) >> 2;
	localparam logic [63:0]       SQ_BIT_TOP = 64'd1 << 62;

	typedef enum logic [1:0] {
		FUNC_LOAD_MATRIX = 2'd0,
		FUNC_LOAD_TARGET = 2'd1,
		FUNC_START       = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		CFG_LIPSCHITZ = 3'd0,
		CFG_LAM_NONNEG = 3'd1,
		CFG_LAM_SPARSE = 3'd2,
		CFG_LAM_ENERGY = 3'd3,
		CFG_ITERATIONS = 3'd4,
		CFG_TEMPLATES = 3'd5,
		CFG_DIMENSION = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_THR,
		S_THRW,
		S_ITER,
		S_MTW,
		S_MRD,
		S_MMUL,
		S_MWR,
		S_MAC,
		S_MDRAIN,
		S_PEN,
		S_RES,
		S_DIVW,
		S_PROX,
		S_TSQ,
		S_ARG,
		S_SQRT,
		S_TUPD,
		S_ORD,
		S_OLD
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  num;
		logic [WORD_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

/* hw/rtl/apls_div.sv */
// ----------------------------------------------------------------------------
// apls_div: shared unsigned restoring divider.
// Produces one quotient bit per cycle and pulses done when the quotient is
// complete; the quotient then holds until the next start.
// ----------------------------------------------------------------------------
module apls_div (
	input  logic              clk,
	input  logic              arst_n,
	input  apls_pkg::div_req_t req,
	output apls_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(apls_pkg::DIV_W);

	logic                           busy_q;
	logic                           done_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [apls_pkg::WORD_W-1:0]    rem_q;
	logic [apls_pkg::WORD_W-1:0]    den_q;
	logic [apls_pkg::DIV_W-1:0]     quo_q;
	logic [apls_pkg::WORD_W:0]      rem_sh;
	logic [apls_pkg::WORD_W:0]      rem_sub;
	logic                           ge;

	assign rem_sh  = {rem_q, quo_q[apls_pkg::DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(apls_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[apls_pkg::WORD_W-1:0] : rem_sh[apls_pkg::WORD_W-1:0];
			quo_q <= {quo_q[apls_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

/* hw/rtl/accelerated_proximal_lasso_solver_unit.sv */
// ----------------------------------------------------------------------------
// Accelerated proximal lasso solver: a load request writes one matrix or target
// word, and loads are taken back to back. A start request clears n entries
// and runs a threshold division, then iterates with the matrix memory feeding
// the multiply-accumulate and the divider, then emits n results. Reset restores
// the register defaults and empties the output.
// ----------------------------------------------------------------------------
module accelerated_proximal_lasso_solver_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [5:0]         row_index,
	input  logic [5:0]         col_index,
	input  logic signed [31:0] word_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         coef_index,
	output logic signed [31:0] coef_value,
	output logic               last_coef,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int IW = apls_pkg::IDX_W;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -66'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [65:0] max0(input logic signed [65:0] v);
		return v[65] ? 66'sd0 : v;
	endfunction

	apls_pkg::state_t   state_q, state_d;
	apls_pkg::div_req_t div_req;
	apls_pkg::div_rsp_t div_rsp;

	logic [15:0]        lip_cfg_q;
	logic signed [31:0] lam_nonneg_q;
	logic signed [31:0] lam_sparse_q;
	logic signed [31:0] lam_energy_q;
	logic [9:0]         iter_cfg_q;
	logic [6:0]         tmpl_cfg_q;
	logic [6:0]         dim_cfg_q;

	logic [IW-1:0] j_q, k_q, k_s1, nlast_q;
	logic [6:0]    nt_q;
	logic [15:0]   lip_q;
	logic [9:0]    it_q;
	logic [31:0]   t_q, tp_q;
	logic          mac_v_s1, mac_v_s2;

	logic [IW-1:0] nlast_w;
	logic [6:0]    n_w;

	logic signed [31:0] gram_mem [apls_pkg::MAX_DIM * apls_pkg::MAX_DIM];
	logic signed [31:0] tgt_mem  [apls_pkg::MAX_DIM];
	logic signed [31:0] cn_mem   [apls_pkg::MAX_DIM];
	logic signed [31:0] cp_mem   [apls_pkg::MAX_DIM];
	logic signed [31:0] y_mem    [apls_pkg::MAX_DIM];
	logic signed [31:0] gram_rd_q, tgt_rd_q, cn_rd_q, cp_rd_q, y_rd_q;

	logic          in_acc, out_free, clamp_w;
	logic          gram_we, tgt_we, cn_we, cp_we, y_we;
	logic [IW-1:0] vaddr;
	logic signed [31:0] cn_wd, cp_wd;

	logic [16:0]        mt_q;
	logic signed [32:0] thr_q;
	logic signed [31:0] c_q, yj_q, tgt_q, cnold_q, g_q;
	logic signed [50:0] mprod_s2;
	logic signed [63:0] gprod_s2, pen_s2, acc_q;
	logic               r_neg_q, big_q;
	logic [63:0]        tsq_s2, sq_rem_q, sq_res_q, sq_bit_q;
	logic [5:0]         out_idx_q;
	logic signed [31:0] out_val_q;
	logic               out_last_q, out_valid_q;

	logic signed [32:0] d_w, ls_ext;
	logic [32:0]        ls_mag;
	logic signed [31:0] y_w, v_w;
	logic signed [63:0] pen_w, r_w;
	logic [63:0]        r_mag, arg_w, sq_try;
	logic signed [64:0] q_w;
	logic signed [65:0] g_ext, thr_ext, prox_w;
	logic [33:0]        tn_w;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = state_q != apls_pkg::S_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign clamp_w  = ({1'b0, j_q} < nt_q) || (j_q == nlast_q);

	assign nlast_w = (dim_cfg_q < 7'd2) ? IW'(1) :
		(dim_cfg_q > 7'(apls_pkg::MAX_DIM)) ? IW'(apls_pkg::MAX_DIM - 1) : IW'(dim_cfg_q - 7'd1);
	assign n_w = 7'(nlast_w) + 7'd1;

	assign d_w     = 33'(cn_rd_q) - 33'(cp_rd_q);
	assign y_w     = sat32(66'(c_q) + 66'(mprod_s2 >>> apls_pkg::FRAC_BITS));
	assign pen_w   = clamp_w ? 64'(lam_nonneg_q) : (pen_s2 >>> apls_pkg::FRAC_BITS);
	assign r_w     = acc_q - 64'(tgt_q) + pen_w;
	assign r_mag   = r_w[63] ? 64'(-r_w) : 64'(r_w);
	assign ls_ext  = 33'(lam_sparse_q);
	assign ls_mag  = ls_ext[32] ? 33'(-ls_ext) : 33'(ls_ext);
	assign q_w     = r_neg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
	assign g_ext   = 66'(g_q);
	assign thr_ext = 66'(thr_q);
	assign prox_w  = clamp_w ? max0(g_ext) : (max0(g_ext - thr_ext) - max0(-g_ext - thr_ext));
	assign v_w     = sat32(prox_w);
	assign arg_w   = (big_q || tsq_s2 > apls_pkg::TSQ_LIMIT) ? '1 : ((tsq_s2 << 2) + apls_pkg::ONE2);
	assign sq_try  = sq_res_q + sq_bit_q;
	assign tn_w    = (34'(apls_pkg::QONE) + 34'(sq_res_q)) >> 1;

	always_comb begin
		state_d = state_q;
		div_req = '0;
		unique case (state_q)
			apls_pkg::S_IDLE: begin
				if (in_acc && func == apls_pkg::FUNC_START) begin
					state_d = apls_pkg::S_CLR;
				end
			end
			apls_pkg::S_CLR: begin
				if (j_q == nlast_q) begin
					state_d = apls_pkg::S_THR;
				end
			end
			apls_pkg::S_THR: begin
				div_req.start = 1'b1;
				div_req.num   = 64'(ls_mag);
				div_req.den   = 32'(lip_q);
				state_d       = apls_pkg::S_THRW;
			end
			apls_pkg::S_THRW: begin
				if (div_rsp.done) begin
					state_d = apls_pkg::S_ITER;
				end
			end
			apls_pkg::S_ITER: begin
				if (it_q == iter_cfg_q) begin
					state_d = apls_pkg::S_ORD;
				end else if (t_q != '0 && tp_q > apls_pkg::QONE) begin
					div_req.start = 1'b1;
					div_req.num   = 64'(tp_q - apls_pkg::QONE) << apls_pkg::FRAC_BITS;
					div_req.den   = t_q;
					state_d       = apls_pkg::S_MTW;
				end else begin
					state_d = apls_pkg::S_MRD;
				end
			end
			apls_pkg::S_MTW: begin
				if (div_rsp.done) begin
					state_d = apls_pkg::S_MRD;
				end
			end
			apls_pkg::S_MRD: state_d = apls_pkg::S_MMUL;
			apls_pkg::S_MMUL: state_d = apls_pkg::S_MWR;
			apls_pkg::S_MWR: begin
				state_d = (j_q == nlast_q) ? apls_pkg::S_MAC : apls_pkg::S_MRD;
			end
			apls_pkg::S_MAC: begin
				if (k_q == nlast_q) begin
					state_d = apls_pkg::S_MDRAIN;
				end
			end
			apls_pkg::S_MDRAIN: begin
				if (!mac_v_s1 && !mac_v_s2) begin
					state_d = apls_pkg::S_PEN;
				end
			end
			apls_pkg::S_PEN: state_d = apls_pkg::S_RES;
			apls_pkg::S_RES: begin
				div_req.start = 1'b1;
				div_req.num   = r_mag;
				div_req.den   = 32'(lip_q);
				state_d       = apls_pkg::S_DIVW;
			end
			apls_pkg::S_DIVW: begin
				if (div_rsp.done) begin
					state_d = apls_pkg::S_PROX;
				end
			end
			apls_pkg::S_PROX: begin
				state_d = (j_q == nlast_q) ? apls_pkg::S_TSQ : apls_pkg::S_MAC;
			end
			apls_pkg::S_TSQ: state_d = apls_pkg::S_ARG;
			apls_pkg::S_ARG: state_d = apls_pkg::S_SQRT;
			apls_pkg::S_SQRT: begin
				if (sq_bit_q[0]) begin
					state_d = apls_pkg::S_TUPD;
				end
			end
			apls_pkg::S_TUPD: state_d = apls_pkg::S_ITER;
			apls_pkg::S_ORD: state_d = apls_pkg::S_OLD;
			apls_pkg::S_OLD: begin
				if (out_free) begin
					state_d = (j_q == nlast_q) ? apls_pkg::S_IDLE : apls_pkg::S_ORD;
				end
			end
			default: state_d = apls_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apls_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lip_cfg_q    <= 16'd1;
			lam_nonneg_q <= '0;
			lam_sparse_q <= '0;
			lam_energy_q <= '0;
			iter_cfg_q   <= '0;
			tmpl_cfg_q   <= '0;
			dim_cfg_q    <= 7'(apls_pkg::MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				apls_pkg::CFG_LIPSCHITZ:  lip_cfg_q    <= cfg_data[15:0];
				apls_pkg::CFG_LAM_NONNEG: lam_nonneg_q <= cfg_data;
				apls_pkg::CFG_LAM_SPARSE: lam_sparse_q <= cfg_data;
				apls_pkg::CFG_LAM_ENERGY: lam_energy_q <= cfg_data;
				apls_pkg::CFG_ITERATIONS: iter_cfg_q   <= cfg_data[9:0];
				apls_pkg::CFG_TEMPLATES:  tmpl_cfg_q   <= cfg_data[6:0];
				apls_pkg::CFG_DIMENSION:  dim_cfg_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			k_q         <= '0;
			it_q        <= '0;
			nlast_q     <= IW'(apls_pkg::MAX_DIM - 1);
			nt_q        <= '0;
			lip_q       <= 16'd1;
			t_q         <= apls_pkg::QONE;
			tp_q        <= apls_pkg::QONE;
			mac_v_s1    <= 1'b0;
			mac_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mac_v_s1 <= state_q == apls_pkg::S_MAC;
			mac_v_s2 <= mac_v_s1;
			if (state_q == apls_pkg::S_OLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				apls_pkg::S_IDLE: begin
					if (in_acc && func == apls_pkg::FUNC_START) begin
						j_q     <= '0;
						it_q    <= '0;
						t_q     <= apls_pkg::QONE;
						tp_q    <= apls_pkg::QONE;
						nlast_q <= nlast_w;
						nt_q    <= (tmpl_cfg_q > n_w) ? n_w : tmpl_cfg_q;
						lip_q   <= (lip_cfg_q == '0) ? 16'd1 : lip_cfg_q;
					end
				end
				apls_pkg::S_CLR: j_q <= (j_q == nlast_q) ? '0 : j_q + 1'b1;
				apls_pkg::S_ITER: j_q <= '0;
				apls_pkg::S_MWR: begin
					j_q <= (j_q == nlast_q) ? '0 : j_q + 1'b1;
					k_q <= '0;
				end
				apls_pkg::S_MAC: k_q <= (k_q == nlast_q) ? '0 : k_q + 1'b1;
				apls_pkg::S_PROX: begin
					j_q <= (j_q == nlast_q) ? '0 : j_q + 1'b1;
					k_q <= '0;
				end
				apls_pkg::S_TUPD: begin
					tp_q <= t_q;
					t_q  <= (tn_w > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : tn_w[31:0];
					it_q <= it_q + 1'b1;
				end
				apls_pkg::S_OLD: begin
					if (out_free) begin
						j_q <= (j_q == nlast_q) ? '0 : j_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		k_s1     <= k_q;
		gprod_s2 <= gram_rd_q * y_rd_q;
		if (mac_v_s1 && k_s1 == j_q) begin
			yj_q <= y_rd_q;
		end
		if (mac_v_s2) begin
			acc_q <= acc_q + (gprod_s2 >>> apls_pkg::FRAC_BITS);
		end
		case (state_q)
			apls_pkg::S_THRW: begin
				if (div_rsp.done) begin
					thr_q <= lam_sparse_q[31] ? -$signed(div_rsp.quo[32:0])
						: $signed(div_rsp.quo[32:0]);
				end
			end
			apls_pkg::S_ITER: mt_q <= '0;
			apls_pkg::S_MTW: begin
				if (div_rsp.done) begin
					mt_q <= div_rsp.quo[16:0];
				end
			end
			apls_pkg::S_MMUL: begin
				c_q      <= cn_rd_q;
				mprod_s2 <= $signed({1'b0, mt_q}) * d_w;
			end
			apls_pkg::S_MWR: acc_q <= '0;
			apls_pkg::S_PEN: begin
				tgt_q   <= tgt_rd_q;
				cnold_q <= cn_rd_q;
				pen_s2  <= lam_energy_q * yj_q;
			end
			apls_pkg::S_RES: r_neg_q <= r_w[63];
			apls_pkg::S_DIVW: begin
				if (div_rsp.done) begin
					g_q <= sat32(66'(yj_q) - 66'(q_w));
				end
			end
			apls_pkg::S_PROX: acc_q <= '0;
			apls_pkg::S_TSQ: begin
				big_q  <= t_q[31];
				tsq_s2 <= 64'(t_q[30:0]) * 64'(t_q[30:0]);
			end
			apls_pkg::S_ARG: begin
				sq_rem_q <= arg_w;
				sq_res_q <= '0;
				sq_bit_q <= apls_pkg::SQ_BIT_TOP;
			end
			apls_pkg::S_SQRT: begin
				if (sq_rem_q >= sq_try) begin
					sq_rem_q <= sq_rem_q - sq_try;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			apls_pkg::S_OLD: begin
				if (out_free) begin
					out_idx_q  <= 6'(j_q);
					out_val_q  <= cn_rd_q;
					out_last_q <= j_q == nlast_q;
				end
			end
			default: ;
		endcase
	end

	assign gram_we = in_acc && func == apls_pkg::FUNC_LOAD_MATRIX;
	assign tgt_we  = in_acc && func == apls_pkg::FUNC_LOAD_TARGET;
	assign cn_we   = state_q == apls_pkg::S_CLR || state_q == apls_pkg::S_PROX;
	assign cp_we   = cn_we;
	assign y_we    = state_q == apls_pkg::S_MWR;
	assign cn_wd   = (state_q == apls_pkg::S_CLR) ? '0 : v_w;
	assign cp_wd   = (state_q == apls_pkg::S_CLR) ? '0 : cnold_q;
	assign vaddr   = (state_q == apls_pkg::S_MAC) ? k_q :
		(state_q == apls_pkg::S_IDLE) ? IW'(row_index) : j_q;

	always_ff @(posedge clk) begin
		if (gram_we) begin
			gram_mem[{IW'(row_index), IW'(col_index)}] <= word_value;
		end
		gram_rd_q <= gram_mem[{j_q, k_q}];
	end

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[vaddr] <= word_value;
		end
		if (cn_we) begin
			cn_mem[vaddr] <= cn_wd;
		end
		if (cp_we) begin
			cp_mem[vaddr] <= cp_wd;
		end
		if (y_we) begin
			y_mem[vaddr] <= y_w;
		end
		tgt_rd_q <= tgt_mem[vaddr];
		cn_rd_q  <= cn_mem[vaddr];
		cp_rd_q  <= cp_mem[vaddr];
		y_rd_q   <= y_mem[vaddr];
	end

	apls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_valid  = out_valid_q;
	assign coef_index = out_idx_q;
	assign coef_value = out_val_q;
	assign last_coef  = out_last_q;

endmodule

/* hw/rtl/apls_checker.sv */
// ----------------------------------------------------------------------------
// apls_checker: port-level checks for the proximal lasso solver.
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module apls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  func,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  coef_index,
	input logic [31:0] coef_value,
	input logic        last_coef
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coef_value) &&
		$stable(coef_index) && $stable(last_coef))
		else $error("Stalled result changed.");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == apls_pkg::FUNC_START |=> in_stall)
		else $error("Solver took a request straight after a start.");

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coef_index == 6'd0 |-> !last_coef)
		else $error("First coefficient flagged as last.");

	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_coef |=> out_valid || in_stall)
		else $error("Solver idle in the middle of a result stream.");

endmodule

bind accelerated_proximal_lasso_solver_unit apls_checker u_apls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.func       (func),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.coef_index (coef_index),
	.coef_value (coef_value),
	.last_coef  (last_coef)
);
